@@ hw/rtl/glr_pkg.sv @@
// Shared types, widths and codes of the gradient line rasterizer.
package glr_pkg;

  localparam int GLR_COORD_BITS  = 12;
  localparam int GLR_DIM_BITS    = 12;
  localparam int GLR_BASE_BITS   = 22;
  localparam int GLR_ADDR_BITS   = 23;
  localparam int GLR_ERR_BITS    = GLR_COORD_BITS + 2;
  localparam int GLR_CHAN_BITS   = 8;
  localparam int GLR_NUM_CHAN    = 3;
  localparam int GLR_COLOR_BITS  = GLR_CHAN_BITS * GLR_NUM_CHAN;
  localparam int GLR_PROD_BITS   = GLR_COORD_BITS + GLR_DIM_BITS;
  localparam int GLR_SUM_BITS    = (GLR_PROD_BITS + 1 > GLR_ADDR_BITS) ?
                                   GLR_PROD_BITS + 1 : GLR_ADDR_BITS;
  localparam int GLR_DIV_CNT_BITS = $clog2(GLR_CHAN_BITS);

  localparam int GLR_QUEUE_DEPTH = 2;
  localparam int GLR_QPTR_BITS   = $clog2(GLR_QUEUE_DEPTH);
  localparam int GLR_QCNT_BITS   = $clog2(GLR_QUEUE_DEPTH + 1);

  localparam int GLR_APB_ADDR_BITS = 4;
  localparam int GLR_APB_DATA_BITS = 32;
  localparam int GLR_REG_IDX_BITS  = 2;

  localparam logic [GLR_REG_IDX_BITS-1:0] GLR_REG_WIDTH  = 2'd0;
  localparam logic [GLR_REG_IDX_BITS-1:0] GLR_REG_HEIGHT = 2'd1;
  localparam logic [GLR_REG_IDX_BITS-1:0] GLR_REG_BASE   = 2'd2;

  localparam logic [GLR_DIM_BITS-1:0]  GLR_WIDTH_RESET  = 12'd320;
  localparam logic [GLR_DIM_BITS-1:0]  GLR_HEIGHT_RESET = 12'd320;
  localparam logic [GLR_BASE_BITS-1:0] GLR_BASE_RESET   = '0;

  localparam logic GLR_REQ_LOAD = 1'b0;
  localparam logic GLR_REQ_STEP = 1'b1;

  typedef logic [GLR_SUM_BITS-1:0]   glr_sum_t;
  typedef logic [GLR_PROD_BITS-1:0]  glr_prod_t;
  typedef logic [GLR_APB_DATA_BITS-1:0] glr_word_t;

  // One command as it travels from the front part to the raster engine.
  typedef struct packed {
    logic                             is_step;
    logic signed [GLR_COORD_BITS-1:0] start_x;
    logic signed [GLR_COORD_BITS-1:0] start_y;
    logic signed [GLR_COORD_BITS-1:0] end_x;
    logic signed [GLR_COORD_BITS-1:0] end_y;
    logic [GLR_COORD_BITS-1:0]        abs_dx;
    logic [GLR_COORD_BITS-1:0]        abs_dy;
    logic [GLR_COORD_BITS-1:0]        span;
    logic                             x_neg;
    logic                             y_neg;
    logic                             x_major;
    logic signed [GLR_ERR_BITS-1:0]   err;
    logic [GLR_COLOR_BITS-1:0]        color_from;
    logic [GLR_COLOR_BITS-1:0]        color_to;
  } glr_cmd_t;

  typedef struct packed {
    logic [GLR_DIM_BITS-1:0]  width;
    logic [GLR_DIM_BITS-1:0]  height;
    logic [GLR_BASE_BITS-1:0] base;
  } glr_cfg_t;

endpackage

@@ hw/rtl/glr_front.sv @@
// Input side: accept beats, classify them and set up line parameters for the engine.
module glr_front (
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic                                     in_req_type,
  input  logic signed [glr_pkg::GLR_COORD_BITS-1:0] in_start_x,
  input  logic signed [glr_pkg::GLR_COORD_BITS-1:0] in_start_y,
  input  logic signed [glr_pkg::GLR_COORD_BITS-1:0] in_end_x,
  input  logic signed [glr_pkg::GLR_COORD_BITS-1:0] in_end_y,
  input  logic [glr_pkg::GLR_CHAN_BITS-1:0]        in_start_red,
  input  logic [glr_pkg::GLR_CHAN_BITS-1:0]        in_start_green,
  input  logic [glr_pkg::GLR_CHAN_BITS-1:0]        in_start_blue,
  input  logic [glr_pkg::GLR_CHAN_BITS-1:0]        in_end_red,
  input  logic [glr_pkg::GLR_CHAN_BITS-1:0]        in_end_green,
  input  logic [glr_pkg::GLR_CHAN_BITS-1:0]        in_end_blue,
  input  logic                                     q_full,
  output logic                                     q_push,
  output glr_pkg::glr_cmd_t                        q_cmd
);

  logic signed [glr_pkg::GLR_COORD_BITS:0] dx;
  logic signed [glr_pkg::GLR_COORD_BITS:0] dy;
  logic signed [glr_pkg::GLR_COORD_BITS:0] dx_mag;
  logic signed [glr_pkg::GLR_COORD_BITS:0] dy_mag;
  logic [glr_pkg::GLR_COORD_BITS-1:0]      adx;
  logic [glr_pkg::GLR_COORD_BITS-1:0]      ady;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    dx     = $signed({in_end_x[glr_pkg::GLR_COORD_BITS-1], in_end_x}) -
             $signed({in_start_x[glr_pkg::GLR_COORD_BITS-1], in_start_x});
    dy     = $signed({in_end_y[glr_pkg::GLR_COORD_BITS-1], in_end_y}) -
             $signed({in_start_y[glr_pkg::GLR_COORD_BITS-1], in_start_y});
    dx_mag = dx[glr_pkg::GLR_COORD_BITS] ? -dx : dx;
    dy_mag = dy[glr_pkg::GLR_COORD_BITS] ? -dy : dy;
    adx    = dx_mag[glr_pkg::GLR_COORD_BITS-1:0];
    ady    = dy_mag[glr_pkg::GLR_COORD_BITS-1:0];

    q_cmd.is_step    = (in_req_type == glr_pkg::GLR_REQ_STEP);
    q_cmd.start_x    = in_start_x;
    q_cmd.start_y    = in_start_y;
    q_cmd.end_x      = in_end_x;
    q_cmd.end_y      = in_end_y;
    q_cmd.abs_dx     = adx;
    q_cmd.abs_dy     = ady;
    q_cmd.span       = (adx > ady) ? adx : ady;
    // Step direction is negative whenever the end does not lie strictly ahead.
    q_cmd.x_neg      = dx[glr_pkg::GLR_COORD_BITS] || (dx == '0);
    q_cmd.y_neg      = dy[glr_pkg::GLR_COORD_BITS] || (dy == '0);
    q_cmd.x_major    = (adx > ady);
    q_cmd.err        = $signed({2'b00, adx}) - $signed({2'b00, ady});
    q_cmd.color_from = {in_start_red, in_start_green, in_start_blue};
    q_cmd.color_to   = {in_end_red, in_end_green, in_end_blue};
  end

endmodule

@@ hw/rtl/glr_queue.sv @@
// Short command queue between the front part and the raster engine.
module glr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  glr_pkg::glr_cmd_t push_cmd,
  output logic              full,
  output logic              head_valid,
  output glr_pkg::glr_cmd_t head_cmd,
  input  logic              pop
);

  glr_pkg::glr_cmd_t                  mem_r [glr_pkg::GLR_QUEUE_DEPTH];
  logic [glr_pkg::GLR_QPTR_BITS-1:0]  wr_ptr_r;
  logic [glr_pkg::GLR_QPTR_BITS-1:0]  rd_ptr_r;
  logic [glr_pkg::GLR_QCNT_BITS-1:0]  count_r;
  logic [glr_pkg::GLR_QPTR_BITS-1:0]  wr_ptr_nxt;
  logic [glr_pkg::GLR_QPTR_BITS-1:0]  rd_ptr_nxt;
  logic [glr_pkg::GLR_QCNT_BITS-1:0]  count_nxt;
  logic                               do_pop;

  assign full       = (count_r == glr_pkg::GLR_QCNT_BITS'(glr_pkg::GLR_QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ hw/rtl/glr_engine.sv @@
// Raster engine: Bresenham walk, incremental color gradient and pixel output register.
module glr_engine (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  glr_pkg::glr_cfg_t                         cfg,
  input  logic                                      q_valid,
  input  glr_pkg::glr_cmd_t                         q_cmd,
  output logic                                      q_pop,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic                                      out_pixel_valid,
  output logic                                      out_on_screen,
  output logic signed [glr_pkg::GLR_COORD_BITS-1:0] out_pixel_x,
  output logic signed [glr_pkg::GLR_COORD_BITS-1:0] out_pixel_y,
  output logic [glr_pkg::GLR_ADDR_BITS-1:0]         out_pixel_address,
  output logic [glr_pkg::GLR_COLOR_BITS-1:0]        out_pixel_color,
  output logic                                      out_last_pixel
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_PIX  = 2'd2;

  localparam int C  = glr_pkg::GLR_COORD_BITS;
  localparam int E  = glr_pkg::GLR_ERR_BITS;
  localparam int CH = glr_pkg::GLR_CHAN_BITS;
  localparam int NC = glr_pkg::GLR_NUM_CHAN;

  logic [1:0] state_r, state_nxt;

  // Line state
  logic                   line_active_r, line_active_nxt;
  logic signed [C-1:0]    cur_x_r, cur_x_nxt;
  logic signed [C-1:0]    cur_y_r, cur_y_nxt;
  logic signed [C-1:0]    tgt_x_r, tgt_x_nxt;
  logic signed [C-1:0]    tgt_y_r, tgt_y_nxt;
  logic                   x_neg_r, x_neg_nxt;
  logic                   y_neg_r, y_neg_nxt;
  logic [C-1:0]           abs_dx_r, abs_dx_nxt;
  logic [C-1:0]           abs_dy_r, abs_dy_nxt;
  logic signed [E-1:0]    err_r, err_nxt;
  logic                   x_major_r, x_major_nxt;
  logic [C-1:0]           k_r, k_nxt;
  logic [C-1:0]           span_r, span_nxt;
  logic [glr_pkg::GLR_COLOR_BITS-1:0] from_r, from_nxt;
  logic [glr_pkg::GLR_COLOR_BITS-1:0] to_r, to_nxt;

  // Per channel gradient tracking: |delta| = qd*span + rd, |delta|*k = acc_q*span + acc_rem
  logic [CH-1:0] div_num_r [NC];
  logic [CH-1:0] div_num_nxt [NC];
  logic [CH-1:0] qd_r [NC];
  logic [CH-1:0] qd_nxt [NC];
  logic [C-1:0]  rd_r [NC];
  logic [C-1:0]  rd_nxt [NC];
  logic [CH-1:0] acc_q_r [NC];
  logic [CH-1:0] acc_q_nxt [NC];
  logic [C-1:0]  acc_rem_r [NC];
  logic [C-1:0]  acc_rem_nxt [NC];
  logic [NC-1:0] dneg_r, dneg_nxt;
  logic [glr_pkg::GLR_DIV_CNT_BITS-1:0] div_cnt_r, div_cnt_nxt;

  // Pixel stage between the walk and the address add
  logic                   pv_r, pv_nxt;
  logic                   vis_r, vis_nxt;
  logic                   plast_r, plast_nxt;
  logic signed [C-1:0]    px_r, px_nxt;
  logic signed [C-1:0]    py_r, py_nxt;
  glr_pkg::glr_prod_t     prod_r, prod_nxt;
  logic [glr_pkg::GLR_COLOR_BITS-1:0] pcol_r, pcol_nxt;

  // Output register
  logic                   ov_r, ov_nxt;
  logic                   o_pv_r, o_vis_r, o_last_r;
  logic signed [C-1:0]    o_x_r, o_y_r;
  logic [glr_pkg::GLR_ADDR_BITS-1:0]  o_addr_r;
  logic [glr_pkg::GLR_COLOR_BITS-1:0] o_col_r;
  logic                   o_load;
  glr_pkg::glr_sum_t      addr_sum;

  assign out_valid         = ov_r;
  assign out_pixel_valid   = o_pv_r;
  assign out_on_screen     = o_vis_r;
  assign out_pixel_x       = o_x_r;
  assign out_pixel_y       = o_y_r;
  assign out_pixel_address = o_addr_r;
  assign out_pixel_color   = o_col_r;
  assign out_last_pixel    = o_last_r;

  assign o_load   = (state_r == ST_PIX) && (!ov_r || out_ready);
  assign addr_sum = glr_pkg::glr_sum_t'(cfg.base) + glr_pkg::glr_sum_t'(prod_r) +
                    glr_pkg::glr_sum_t'($unsigned(px_r));

  always_comb begin
    logic [CH-1:0]        f_ch, t_ch, mag;
    logic [C:0]           trial, tdiff, rsum, rdiff;
    logic signed [E:0]    e2, adx_s, ady_s;
    logic signed [E-1:0]  adx_e, ady_e;
    logic                 step_x, step_y, major_step, last_c, vis_c;
    logic [glr_pkg::GLR_COLOR_BITS-1:0] col_c;

    mag   = '0;
    trial = '0;
    tdiff = '0;
    rsum  = '0;
    rdiff = '0;

    state_nxt       = state_r;
    line_active_nxt = line_active_r;
    cur_x_nxt       = cur_x_r;
    cur_y_nxt       = cur_y_r;
    tgt_x_nxt       = tgt_x_r;
    tgt_y_nxt       = tgt_y_r;
    x_neg_nxt       = x_neg_r;
    y_neg_nxt       = y_neg_r;
    abs_dx_nxt      = abs_dx_r;
    abs_dy_nxt      = abs_dy_r;
    err_nxt         = err_r;
    x_major_nxt     = x_major_r;
    k_nxt           = k_r;
    span_nxt        = span_r;
    from_nxt        = from_r;
    to_nxt          = to_r;
    dneg_nxt        = dneg_r;
    div_cnt_nxt     = div_cnt_r;
    for (int c = 0; c < NC; c++) begin
      div_num_nxt[c] = div_num_r[c];
      qd_nxt[c]      = qd_r[c];
      rd_nxt[c]      = rd_r[c];
      acc_q_nxt[c]   = acc_q_r[c];
      acc_rem_nxt[c] = acc_rem_r[c];
    end
    pv_nxt    = pv_r;
    vis_nxt   = vis_r;
    plast_nxt = plast_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    prod_nxt  = prod_r;
    pcol_nxt  = pcol_r;
    q_pop     = 1'b0;

    // Walk decisions for the current pixel
    e2         = $signed({err_r, 1'b0});
    adx_s      = $signed({{(E + 1 - C){1'b0}}, abs_dx_r});
    ady_s      = $signed({{(E + 1 - C){1'b0}}, abs_dy_r});
    adx_e      = $signed({{(E - C){1'b0}}, abs_dx_r});
    ady_e      = $signed({{(E - C){1'b0}}, abs_dy_r});
    step_x     = (e2 >= -ady_s);
    step_y     = (e2 <= adx_s);
    major_step = x_major_r ? step_x : step_y;
    last_c     = (cur_x_r == tgt_x_r) && (cur_y_r == tgt_y_r);
    vis_c      = !cur_x_r[C-1] && !cur_y_r[C-1] &&
                 ($unsigned(cur_x_r) < cfg.width) && ($unsigned(cur_y_r) < cfg.height);

    // Gradient color: start at k of zero, end once k reaches the span
    col_c = '0;
    for (int c = 0; c < NC; c++) begin
      f_ch = from_r[c*CH +: CH];
      t_ch = to_r[c*CH +: CH];
      if (k_r == '0) begin
        col_c[c*CH +: CH] = f_ch;
      end else if (k_r >= span_r) begin
        col_c[c*CH +: CH] = t_ch;
      end else begin
        col_c[c*CH +: CH] = dneg_r[c] ? f_ch - acc_q_r[c] : f_ch + acc_q_r[c];
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (!q_cmd.is_step) begin
            // Latch a new line, dropping any line still in progress
            line_active_nxt = 1'b1;
            cur_x_nxt   = q_cmd.start_x;
            cur_y_nxt   = q_cmd.start_y;
            tgt_x_nxt   = q_cmd.end_x;
            tgt_y_nxt   = q_cmd.end_y;
            x_neg_nxt   = q_cmd.x_neg;
            y_neg_nxt   = q_cmd.y_neg;
            abs_dx_nxt  = q_cmd.abs_dx;
            abs_dy_nxt  = q_cmd.abs_dy;
            err_nxt     = q_cmd.err;
            x_major_nxt = q_cmd.x_major;
            span_nxt    = q_cmd.span;
            k_nxt       = '0;
            from_nxt    = q_cmd.color_from;
            to_nxt      = q_cmd.color_to;
            div_cnt_nxt = '0;
            for (int c = 0; c < NC; c++) begin
              f_ch = q_cmd.color_from[c*CH +: CH];
              t_ch = q_cmd.color_to[c*CH +: CH];
              dneg_nxt[c]    = (t_ch < f_ch);
              mag            = (t_ch < f_ch) ? f_ch - t_ch : t_ch - f_ch;
              div_num_nxt[c] = mag;
              qd_nxt[c]      = '0;
              rd_nxt[c]      = '0;
              acc_q_nxt[c]   = '0;
              acc_rem_nxt[c] = '0;
            end
            state_nxt = ST_DIV;
          end else begin
            pv_nxt    = line_active_r;
            vis_nxt   = line_active_r && vis_c;
            plast_nxt = line_active_r && last_c;
            px_nxt    = line_active_r ? cur_x_r : '0;
            py_nxt    = line_active_r ? cur_y_r : '0;
            prod_nxt  = glr_pkg::glr_prod_t'($unsigned(cur_y_r)) *
                        glr_pkg::glr_prod_t'(cfg.width);
            pcol_nxt  = line_active_r ? col_c : '0;
            if (line_active_r) begin
              if (last_c) begin
                line_active_nxt = 1'b0;
              end else begin
                err_nxt = err_r - (step_x ? ady_e : '0) + (step_y ? adx_e : '0);
                if (step_x) begin
                  cur_x_nxt = x_neg_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
                end
                if (step_y) begin
                  cur_y_nxt = y_neg_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
                end
                if (major_step) begin
                  k_nxt = k_r + 1'b1;
                  for (int c = 0; c < NC; c++) begin
                    rsum = {1'b0, acc_rem_r[c]} + {1'b0, rd_r[c]};
                    if (rsum >= {1'b0, span_r}) begin
                      rdiff          = rsum - {1'b0, span_r};
                      acc_rem_nxt[c] = rdiff[C-1:0];
                      acc_q_nxt[c]   = acc_q_r[c] + qd_r[c] + 1'b1;
                    end else begin
                      acc_rem_nxt[c] = rsum[C-1:0];
                      acc_q_nxt[c]   = acc_q_r[c] + qd_r[c];
                    end
                  end
                end
              end
            end
            state_nxt = ST_PIX;
          end
        end
      end
      ST_DIV: begin
        // One restoring division bit per channel per cycle: |delta| / span
        for (int c = 0; c < NC; c++) begin
          trial = {rd_r[c], div_num_r[c][CH-1]};
          if (trial >= {1'b0, span_r}) begin
            tdiff     = trial - {1'b0, span_r};
            rd_nxt[c] = tdiff[C-1:0];
            qd_nxt[c] = {qd_r[c][CH-2:0], 1'b1};
          end else begin
            rd_nxt[c] = trial[C-1:0];
            qd_nxt[c] = {qd_r[c][CH-2:0], 1'b0};
          end
          div_num_nxt[c] = {div_num_r[c][CH-2:0], 1'b0};
        end
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == glr_pkg::GLR_DIV_CNT_BITS'(CH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PIX: begin
        if (o_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (o_load) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      line_active_r <= 1'b0;
      div_cnt_r     <= '0;
      ov_r          <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      line_active_r <= line_active_nxt;
      div_cnt_r     <= div_cnt_nxt;
      ov_r          <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r   <= cur_x_nxt;
    cur_y_r   <= cur_y_nxt;
    tgt_x_r   <= tgt_x_nxt;
    tgt_y_r   <= tgt_y_nxt;
    x_neg_r   <= x_neg_nxt;
    y_neg_r   <= y_neg_nxt;
    abs_dx_r  <= abs_dx_nxt;
    abs_dy_r  <= abs_dy_nxt;
    err_r     <= err_nxt;
    x_major_r <= x_major_nxt;
    k_r       <= k_nxt;
    span_r    <= span_nxt;
    from_r    <= from_nxt;
    to_r      <= to_nxt;
    dneg_r    <= dneg_nxt;
    for (int c = 0; c < NC; c++) begin
      div_num_r[c] <= div_num_nxt[c];
      qd_r[c]      <= qd_nxt[c];
      rd_r[c]      <= rd_nxt[c];
      acc_q_r[c]   <= acc_q_nxt[c];
      acc_rem_r[c] <= acc_rem_nxt[c];
    end
    pv_r    <= pv_nxt;
    vis_r   <= vis_nxt;
    plast_r <= plast_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    prod_r  <= prod_nxt;
    pcol_r  <= pcol_nxt;
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      o_pv_r   <= pv_r;
      o_vis_r  <= vis_r;
      o_last_r <= plast_r;
      o_x_r    <= px_r;
      o_y_r    <= py_r;
      o_addr_r <= vis_r ? addr_sum[glr_pkg::GLR_ADDR_BITS-1:0] : '0;
      o_col_r  <= pcol_r;
    end
  end

endmodule

@@ hw/rtl/gradient_line_raster.sv @@
// Top level of the gradient line rasterizer: APB registers, front part, queue and engine.
// A step beat passes the queue, pixel stage and output register; output stalls add delay.
// The engine takes a new step beat only after the last result is in the output register.
// A load beat holds the engine for one latch step and then 8 gradient division steps.
// The 2-entry command queue takes beats while the engine works or output stalls until full.
// Reset (synchronous, rst_n low) drops any line, empties queue and output; registers reset.
module gradient_line_raster (
  input  logic                                       clk,
  input  logic                                       rst_n,
  // APB-style configuration port
  input  logic                                       psel,
  input  logic                                       penable,
  input  logic                                       pwrite,
  input  logic [glr_pkg::GLR_APB_ADDR_BITS-1:0]      paddr,
  input  logic [glr_pkg::GLR_APB_DATA_BITS-1:0]      pwdata,
  output logic [glr_pkg::GLR_APB_DATA_BITS-1:0]      prdata,
  output logic                                       pready,
  // Input beats
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic                                       in_req_type,
  input  logic signed [glr_pkg::GLR_COORD_BITS-1:0]  in_start_x,
  input  logic signed [glr_pkg::GLR_COORD_BITS-1:0]  in_start_y,
  input  logic signed [glr_pkg::GLR_COORD_BITS-1:0]  in_end_x,
  input  logic signed [glr_pkg::GLR_COORD_BITS-1:0]  in_end_y,
  input  logic [glr_pkg::GLR_CHAN_BITS-1:0]          in_start_red,
  input  logic [glr_pkg::GLR_CHAN_BITS-1:0]          in_start_green,
  input  logic [glr_pkg::GLR_CHAN_BITS-1:0]          in_start_blue,
  input  logic [glr_pkg::GLR_CHAN_BITS-1:0]          in_end_red,
  input  logic [glr_pkg::GLR_CHAN_BITS-1:0]          in_end_green,
  input  logic [glr_pkg::GLR_CHAN_BITS-1:0]          in_end_blue,
  // Result beats
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic                                       out_pixel_valid,
  output logic                                       out_on_screen,
  output logic signed [glr_pkg::GLR_COORD_BITS-1:0]  out_pixel_x,
  output logic signed [glr_pkg::GLR_COORD_BITS-1:0]  out_pixel_y,
  output logic [glr_pkg::GLR_ADDR_BITS-1:0]          out_pixel_address,
  output logic [glr_pkg::GLR_COLOR_BITS-1:0]         out_pixel_color,
  output logic                                       out_last_pixel
);

  // Configuration registers
  glr_pkg::glr_cfg_t cfg_r, cfg_nxt;
  logic [glr_pkg::GLR_REG_IDX_BITS-1:0] reg_idx;
  logic              reg_wr;

  // Front to queue and queue to engine
  glr_pkg::glr_cmd_t front_cmd;
  glr_pkg::glr_cmd_t head_cmd;
  logic              q_push;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;

  // Registers sit at word addresses; the low byte-lane bits are ignored.
  assign reg_idx = paddr[glr_pkg::GLR_APB_ADDR_BITS-1:2];
  assign reg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  // Write decode: drop writes beyond the register list.
  always_comb begin
    cfg_nxt = cfg_r;
    if (reg_wr) begin
      unique case (reg_idx)
        glr_pkg::GLR_REG_WIDTH:  cfg_nxt.width  = pwdata[glr_pkg::GLR_DIM_BITS-1:0];
        glr_pkg::GLR_REG_HEIGHT: cfg_nxt.height = pwdata[glr_pkg::GLR_DIM_BITS-1:0];
        glr_pkg::GLR_REG_BASE:   cfg_nxt.base   = pwdata[glr_pkg::GLR_BASE_BITS-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  // Read mux: unused addresses read as zero.
  always_comb begin
    unique case (reg_idx)
      glr_pkg::GLR_REG_WIDTH:  prdata = glr_pkg::glr_word_t'(cfg_r.width);
      glr_pkg::GLR_REG_HEIGHT: prdata = glr_pkg::glr_word_t'(cfg_r.height);
      glr_pkg::GLR_REG_BASE:   prdata = glr_pkg::glr_word_t'(cfg_r.base);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= glr_pkg::GLR_WIDTH_RESET;
      cfg_r.height <= glr_pkg::GLR_HEIGHT_RESET;
      cfg_r.base   <= glr_pkg::GLR_BASE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front part: classify beats and precompute line setup
  glr_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .in_start_red   (in_start_red),
    .in_start_green (in_start_green),
    .in_start_blue  (in_start_blue),
    .in_end_red     (in_end_red),
    .in_end_green   (in_end_green),
    .in_end_blue    (in_end_blue),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (front_cmd)
  );

  // Decoupling queue: lets the front keep taking beats while the engine is busy
  glr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (front_cmd),
    .full       (q_full),
    .head_valid (q_valid),
    .head_cmd   (head_cmd),
    .pop        (q_pop)
  );

  // Engine: walk the line, track the gradient, form the address, hold the result beat
  glr_engine u_engine (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_valid           (q_valid),
    .q_cmd             (head_cmd),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_valid   (out_pixel_valid),
    .out_on_screen     (out_on_screen),
    .out_pixel_x       (out_pixel_x),
    .out_pixel_y       (out_pixel_y),
    .out_pixel_address (out_pixel_address),
    .out_pixel_color   (out_pixel_color),
    .out_last_pixel    (out_last_pixel)
  );

endmodule
